// ----- rtl/core/ffcd_pkg.sv -----
// Shared types and constants for the freefall chute deploy sequencer.
`timescale 1ns / 1ps
`default_nettype none

package ffcd_pkg;

    // Field widths fixed by the sample and register formats
    localparam int LIMIT_W    = 32;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Register reset values: 0.3 g squared at 4096 counts per g, 2000 ms, 1000 ms
    localparam logic [LIMIT_W-1:0] LIMIT_SQ_RESET     = 32'd1510441;
    localparam logic [MS_W-1:0]    FAILSAFE_MS_RESET  = 16'd2000;
    localparam logic [MS_W-1:0]    LOG_INTERVAL_RESET = 16'd1000;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LIMIT_SQ     = 2'd0,
        REG_FAILSAFE_MS  = 2'd1,
        REG_LOG_INTERVAL = 2'd2
    } reg_idx_t;

    // Live configuration handed to the decision stage
    typedef struct packed {
        logic [LIMIT_W-1:0] limit_sq;
        logic [MS_W-1:0]    failsafe_ms;
        logic [MS_W-1:0]    log_interval_ms;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffcd_cfg_regs.sv -----
// APB configuration register file for the freefall chute deploy sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ffcd_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ffcd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ffcd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ffcd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output ffcd_pkg::cfg_t                          cfg
);

    ffcd_pkg::cfg_t   cfg_reg;
    ffcd_pkg::cfg_t   cfg_next;
    ffcd_pkg::reg_idx_t reg_idx;
    logic             wr_en;

    assign reg_idx = ffcd_pkg::reg_idx_t'(paddr[ffcd_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Decode the write; drop bits above each register's width
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                ffcd_pkg::REG_LIMIT_SQ: begin
                    cfg_next.limit_sq = pwdata[ffcd_pkg::LIMIT_W-1:0];
                end
                ffcd_pkg::REG_FAILSAFE_MS: begin
                    cfg_next.failsafe_ms = pwdata[ffcd_pkg::MS_W-1:0];
                end
                ffcd_pkg::REG_LOG_INTERVAL: begin
                    cfg_next.log_interval_ms = pwdata[ffcd_pkg::MS_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limit_sq        <= ffcd_pkg::LIMIT_SQ_RESET;
            cfg_reg.failsafe_ms     <= ffcd_pkg::FAILSAFE_MS_RESET;
            cfg_reg.log_interval_ms <= ffcd_pkg::LOG_INTERVAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            ffcd_pkg::REG_LIMIT_SQ: begin
                prdata = cfg_reg.limit_sq;
            end
            ffcd_pkg::REG_FAILSAFE_MS: begin
                prdata = ffcd_pkg::APB_DATA_W'(cfg_reg.failsafe_ms);
            end
            ffcd_pkg::REG_LOG_INTERVAL: begin
                prdata = ffcd_pkg::APB_DATA_W'(cfg_reg.log_interval_ms);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ffcd_square_stage.sv -----
// Pipeline stage that squares the three acceleration axes.
`timescale 1ns / 1ps
`default_nettype none

module ffcd_square_stage #(
    parameter int AW = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              up_valid,
    output logic                                   up_ready,
    input  wire logic signed [AW-1:0]              up_x,
    input  wire logic signed [AW-1:0]              up_y,
    input  wire logic signed [AW-1:0]              up_z,
    input  wire logic        [ffcd_pkg::TIME_W-1:0] up_time,
    output logic                                   dn_valid,
    input  wire logic                              dn_ready,
    output logic             [2*AW-1:0]            dn_sq_x,
    output logic             [2*AW-1:0]            dn_sq_y,
    output logic             [2*AW-1:0]            dn_sq_z,
    output logic             [ffcd_pkg::TIME_W-1:0] dn_time
);

    logic signed [2*AW-1:0]             prod_x;
    logic signed [2*AW-1:0]             prod_y;
    logic signed [2*AW-1:0]             prod_z;
    logic                               valid_reg;
    logic        [2*AW-1:0]             sq_x_reg;
    logic        [2*AW-1:0]             sq_y_reg;
    logic        [2*AW-1:0]             sq_z_reg;
    logic        [ffcd_pkg::TIME_W-1:0] time_reg;
    logic                               load;

    // A square of a two's complement value is never negative
    assign prod_x = up_x * up_x;
    assign prod_y = up_y * up_y;
    assign prod_z = up_z * up_z;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    // Hold the squares until the decision stage takes them
    always_ff @(posedge aclk) begin
        if (load) begin
            sq_x_reg <= $unsigned(prod_x);
            sq_y_reg <= $unsigned(prod_y);
            sq_z_reg <= $unsigned(prod_z);
            time_reg <= up_time;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_sq_x  = sq_x_reg;
    assign dn_sq_y  = sq_y_reg;
    assign dn_sq_z  = sq_z_reg;
    assign dn_time  = time_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ffcd_decide_stage.sv -----
// Release, deploy and log-tick decision with sequencer state and result register.
`timescale 1ns / 1ps
`default_nettype none

module ffcd_decide_stage #(
    parameter int AW = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ffcd_pkg::cfg_t                     cfg,
    input  wire logic                               up_valid,
    output logic                                    up_ready,
    input  wire logic       [2*AW-1:0]              up_sq_x,
    input  wire logic       [2*AW-1:0]              up_sq_y,
    input  wire logic       [2*AW-1:0]              up_sq_z,
    input  wire logic       [ffcd_pkg::TIME_W-1:0]  up_time,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_is_released,
    output logic                                    m_is_deployed,
    output logic                                    m_deploy_pulse,
    output logic                                    m_log_tick
);

    localparam int SQ_W  = 2 * AW;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > ffcd_pkg::LIMIT_W) ? SUM_W : ffcd_pkg::LIMIT_W;

    logic [SUM_W-1:0]            mag_sq;
    logic [CMP_W-1:0]            mag_cmp;
    logic [CMP_W-1:0]            lim_cmp;
    logic                        below;
    logic                        above;
    logic [ffcd_pkg::TIME_W-1:0] stamp;
    logic [ffcd_pkg::TIME_W-1:0] since_release;
    logic [ffcd_pkg::TIME_W-1:0] since_log;
    logic                        timed_out;
    logic                        advance;

    logic                        released_reg;
    logic                        released_next;
    logic                        deployed_reg;
    logic                        deployed_next;
    logic [ffcd_pkg::TIME_W-1:0] release_stamp_reg;
    logic [ffcd_pkg::TIME_W-1:0] last_log_reg;
    logic [ffcd_pkg::TIME_W-1:0] last_log_next;
    logic                        pulse_next;
    logic                        tick_next;
    logic                        valid_reg;
    logic                        pulse_reg;
    logic                        tick_reg;

    assign up_ready = !valid_reg || m_ready;
    assign advance  = up_valid && up_ready;

    // Sum of squares against the threshold
    assign mag_sq  = SUM_W'(up_sq_x) + SUM_W'(up_sq_y) + SUM_W'(up_sq_z);
    assign mag_cmp = CMP_W'(mag_sq);
    assign lim_cmp = CMP_W'(cfg.limit_sq);
    assign below   = mag_cmp < lim_cmp;
    assign above   = mag_cmp > lim_cmp;

    // Wrapping elapsed times
    assign stamp         = released_reg ? release_stamp_reg : up_time;
    assign since_release = up_time - stamp;
    assign since_log     = up_time - last_log_reg;
    assign timed_out     = since_release > ffcd_pkg::TIME_W'(cfg.failsafe_ms);

    // Release latches first; the word that releases sees zero elapsed time and cannot deploy
    always_comb begin
        released_next = released_reg || below;
        pulse_next    = released_next && !deployed_reg && (above || timed_out);
        deployed_next = deployed_reg || pulse_next;
        tick_next     = since_log >= ffcd_pkg::TIME_W'(cfg.log_interval_ms);
        last_log_next = tick_next ? up_time : last_log_reg;
    end

    // Advance state only when a word moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            released_reg      <= 1'b0;
            deployed_reg      <= 1'b0;
            release_stamp_reg <= '0;
            last_log_reg      <= '0;
        end else if (advance) begin
            released_reg      <= released_next;
            deployed_reg      <= deployed_next;
            release_stamp_reg <= stamp;
            last_log_reg      <= last_log_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    // Result payload; flags come from the state that was just written
    always_ff @(posedge aclk) begin
        if (advance) begin
            pulse_reg <= pulse_next;
            tick_reg  <= tick_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_is_released  = released_reg;
    assign m_is_deployed  = deployed_reg;
    assign m_deploy_pulse = pulse_reg;
    assign m_log_tick     = tick_reg;

endmodule

`default_nettype wire

// ----- rtl/core/freefall_chute_deploy_sequencer_top.sv -----
// Top level of the freefall chute deploy sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one accelerometer word (three signed axes plus a millisecond timestamp) per
// cycle while m_ready drains the output, and returns one status word per input: release
// latched, deploy latched, a one-shot deploy pulse and a log tick. m_valid rises once the
// word has passed the input register, square register and result register, and the
// block sustains one word per clock unless m_ready holds it back; the decision stage's
// compare, wrapping subtract and flag update are combinational. A full result register
// does not block intake while the earlier stages have room. The three
// thresholds live at APB byte addresses 0x0 (squared limit), 0x4 (failsafe ms) and
// 0x8 (log interval ms) and should be written only while the block is idle.
module freefall_chute_deploy_sequencer_top #(
    parameter int ACCEL_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ffcd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ffcd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ffcd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [ACCEL_WIDTH-1:0]      s_accel_x,
    input  wire logic signed [ACCEL_WIDTH-1:0]      s_accel_y,
    input  wire logic signed [ACCEL_WIDTH-1:0]      s_accel_z,
    input  wire logic [ffcd_pkg::TIME_W-1:0]        s_time_ms,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_is_released,
    output logic                                    m_is_deployed,
    output logic                                    m_deploy_pulse,
    output logic                                    m_log_tick
);

    ffcd_pkg::cfg_t                     cfg;
    logic                               in_valid_reg;
    logic signed [ACCEL_WIDTH-1:0]      in_x_reg;
    logic signed [ACCEL_WIDTH-1:0]      in_y_reg;
    logic signed [ACCEL_WIDTH-1:0]      in_z_reg;
    logic        [ffcd_pkg::TIME_W-1:0] in_time_reg;
    logic                               sq_up_ready;
    logic                               sq_valid;
    logic                               dec_up_ready;
    logic        [2*ACCEL_WIDTH-1:0]    sq_x;
    logic        [2*ACCEL_WIDTH-1:0]    sq_y;
    logic        [2*ACCEL_WIDTH-1:0]    sq_z;
    logic        [ffcd_pkg::TIME_W-1:0] sq_time;

    ffcd_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register: take a word whenever the square stage can drain this one
    assign s_ready = !in_valid_reg || sq_up_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_x_reg    <= s_accel_x;
            in_y_reg    <= s_accel_y;
            in_z_reg    <= s_accel_z;
            in_time_reg <= s_time_ms;
        end
    end

    ffcd_square_stage #(
        .AW (ACCEL_WIDTH)
    ) u_square_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (in_valid_reg),
        .up_ready (sq_up_ready),
        .up_x     (in_x_reg),
        .up_y     (in_y_reg),
        .up_z     (in_z_reg),
        .up_time  (in_time_reg),
        .dn_valid (sq_valid),
        .dn_ready (dec_up_ready),
        .dn_sq_x  (sq_x),
        .dn_sq_y  (sq_y),
        .dn_sq_z  (sq_z),
        .dn_time  (sq_time)
    );

    ffcd_decide_stage #(
        .AW (ACCEL_WIDTH)
    ) u_decide_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .up_valid       (sq_valid),
        .up_ready       (dec_up_ready),
        .up_sq_x        (sq_x),
        .up_sq_y        (sq_y),
        .up_sq_z        (sq_z),
        .up_time        (sq_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_released  (m_is_released),
        .m_is_deployed  (m_is_deployed),
        .m_deploy_pulse (m_deploy_pulse),
        .m_log_tick     (m_log_tick)
    );

endmodule

`default_nettype wire
